// ----- sv/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the radix digit converter: field widths,
// base limits, controller states and the controller/datapath command and
// status words.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Default width of the value field.
  localparam int DEF_VALUE_BITS = 31;

  // Width of the base field and of one digit.
  localparam int RADIX_W = 4;
  localparam int DIGIT_W = 4;

  // Quotient bits produced by the divider in one cycle.
  localparam int STEP_BITS = 4;

  // Accepted range of bases.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd9;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_READ,
    S_SHOW,
    S_ERR
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new word and clear the digit count
    logic div_step;  // run one divider cycle
    logic store;     // write the remainder as the next digit
    logic rd;        // read the most recent unsent digit
    logic emit;      // load the digit just read into the output register
    logic emit_err;  // load the error result into the output register
  } rdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic radix_bad;  // base of the incoming word is out of range
    logic q_zero;     // quotient after a full division is zero
    logic cnt_zero;   // no stored digits remain
    logic out_free;   // output register can take a word this cycle
  } rdc_stat_t;

endpackage

// ----- sv/rdc_req_if.sv -----
// ----------------------------------------------------------------------------
// rdc_req_if
// Input channel: a value to convert and its target base.
// ----------------------------------------------------------------------------
interface rdc_req_if import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) ();

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);

endinterface

// ----- sv/rdc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rdc_rsp_if
// Output channel: one digit per word, with end-of-run and error flags.
// ----------------------------------------------------------------------------
interface rdc_rsp_if import rdc_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last;
  logic               bad_radix;

  modport source (output valid, output digit, output last, output bad_radix, input ready);
  modport sink   (input valid, input digit, input last, input bad_radix, output ready);

endinterface

// ----- sv/rdc_ram.sv -----
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/rdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdc_ctrl
// Controller: sequences the divider over each digit, then replays the stored
// digits most significant first, or the error word, into the output register.
// ----------------------------------------------------------------------------
module rdc_ctrl import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rdc_stat_t st,
  output rdc_cmd_t  cmd
);

  localparam int NSTEP  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int SCNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [SCNT_W-1:0] LAST_STP = SCNT_W'(NSTEP - 1);

  ctl_state_t        state, state_next;
  logic [SCNT_W-1:0] stp, stp_next;

  // State and divider cycle counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stp   <= '0;
    end else begin
      state <= state_next;
      stp   <= stp_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    stp_next   = stp;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (st.radix_bad) begin
            state_next = S_ERR;
          end else begin
            cmd.load   = 1'b1;
            stp_next   = '0;
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stp == LAST_STP) begin
          stp_next   = '0;
          state_next = S_STORE;
        end else begin
          stp_next = stp + SCNT_W'(1);
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = st.q_zero ? S_READ : S_DIV;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = st.cnt_zero ? S_IDLE : S_READ;
        end
      end
      S_ERR: begin
        if (st.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/rdc_datapath.sv -----
// ----------------------------------------------------------------------------
// rdc_datapath
// Datapath: a shared divider that retires four quotient bits a cycle, a
// digit store filled least significant first, and the output register.
// ----------------------------------------------------------------------------
module rdc_datapath import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rdc_cmd_t              cmd,
  output rdc_stat_t             st,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [RADIX_W-1:0]    in_radix,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [DIGIT_W-1:0]    out_digit,
  output logic                  out_last,
  output logic                  out_bad
);

  localparam int NSTEP    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = NSTEP * STEP_BITS;
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);
  localparam int AW       = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [PAD_BITS-1:0] dvd, dvd_next;
  logic [RADIX_W-1:0]  rem, rem_next;
  logic [RADIX_W-1:0]  radix_r;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_m1;
  logic [DIGIT_W-1:0] rdata;

  // Four restoring division steps on the narrow remainder. The dividend
  // register shifts left and collects the quotient bits at the bottom.
  always_comb begin
    logic [RADIX_W:0] t;
    rem_next = rem;
    dvd_next = dvd;
    for (int i = 0; i < STEP_BITS; i++) begin
      t        = {rem_next, dvd_next[PAD_BITS-1]};
      dvd_next = {dvd_next[PAD_BITS-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        rem_next    = RADIX_W'(t - {1'b0, radix_r});
        dvd_next[0] = 1'b1;
      end else begin
        rem_next = t[RADIX_W-1:0];
      end
    end
  end

  assign cnt_m1 = cnt - CNT_W'(1);

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd     <= PAD_BITS'(in_value);
      rem     <= '0;
      radix_r <= in_radix;
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end else if (cmd.store) begin
      rem <= '0;
    end
  end

  // Digit count: grows while dividing, shrinks while replaying.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.store) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.rd) begin
      cnt <= cnt_m1;
    end
  end

  // Digit store.
  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (cnt[AW-1:0]),
    .wdata (rem),
    .re    (cmd.rd),
    .raddr (cnt_m1[AW-1:0]),
    .rdata (rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_digit <= rdata;
      out_last  <= (cnt == '0);
      out_bad   <= 1'b0;
    end else if (cmd.emit_err) begin
      out_digit <= '0;
      out_last  <= 1'b1;
      out_bad   <= 1'b1;
    end
  end

  // Status back to the controller.
  always_comb begin
    st.radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
    st.q_zero    = (dvd == '0);
    st.cnt_zero  = (cnt == '0);
    st.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- sv/radix_digit_converter_top.sv -----
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts an unsigned value to base 2 to 9 and sends its digits most
// significant first, one word per digit, the last one flagged.
//
//   channel  direction  payload                     words per item
//   req      in         value, radix                1
//   rsp      out        digit, last, bad_radix      1 to VALUE_BITS
//
// The divider retires four quotient bits a cycle for each digit. Replay
// reads each digit from the digit store, then loads it into the output
// register. A rejected base sends the controller to its error state, which
// loads the error word once the output register is free.
// The next item is taken as soon as the last digit sits in the output
// register; a stalled sink holds the replay, not the divider state.
// Reset is synchronous and clears the controller and the output valid.
// ----------------------------------------------------------------------------
module radix_digit_converter_top import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  rdc_req_if.sink    req,
  rdc_rsp_if.source  rsp
);

  rdc_cmd_t  cmd;
  rdc_stat_t st;

  rdc_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_value  (req.value),
    .in_radix  (req.radix),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .out_digit (rsp.digit),
    .out_last  (rsp.last),
    .out_bad   (rsp.bad_radix)
  );

endmodule

// ----- sv/rdc_checker.sv -----
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module rdc_checker import rdc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIGIT_W-1:0] out_digit,
  input logic               out_last,
  input logic               out_bad
);

  // No word is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // An error word is a single, flagged, zero word.
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_bad |-> out_last && (out_digit == '0))
    else $error("malformed error word");

  // Digits never exceed the largest digit of base 9.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_bad |-> (out_digit <= DIGIT_W'(RADIX_MAX - 4'd1)))
    else $error("digit out of range");

  // While a run is still being sent, no new item is taken.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a digit run");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_digit)
      && $stable(out_last) && $stable(out_bad))
    else $error("stalled word changed");

endmodule

bind radix_digit_converter_top rdc_checker u_rdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_digit (rsp.digit),
  .out_last  (rsp.last),
  .out_bad   (rsp.bad_radix)
);

// ----- bench/radix_digit_converter_top_tb.sv -----
// ----------------------------------------------------------------------------
// radix_digit_converter_top_tb
// Self-checking bench for the radix digit converter. A short table of
// directed items covers zero, the largest value, every base, rejected bases
// and exact powers of each base but 4, plus values one below a power. Random
// items follow, with random idle cycles on both channels and one long output
// stall. Each item with no typed word is run through an in-bench conversion,
// and each word out is checked field by field against the oldest still due.
// ----------------------------------------------------------------------------
module radix_digit_converter_top_tb import rdc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VBITS = DEF_VALUE_BITS;

  // Run length and stall shaping.
  localparam int RANDOM_ITEMS = 337;
  localparam int CALM_ITEM_LO = 120;
  localparam int CALM_ITEM_HI = 180;
  localparam int HOLD_AT_WORD = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_WORD_LO = 1000;
  localparam int CALM_WORD_HI = 1800;
  localparam int DRAIN_CYCLES = 64;

  // Slowest correct run: 360 items of 31 digits, each digit with its divider,
  // replay and output stall time, plus input gaps and the long hold. The limit
  // leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [VBITS-1:0] VALUE_MAX = '1;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_radix;
  } digit_word_t;

  typedef struct packed {
    logic [VBITS-1:0]   value;
    logic [RADIX_W-1:0] radix;
    logic               known;
    digit_word_t        typed;
  } stim_row_t;

  localparam digit_word_t NO_WORD   = '0;
  localparam digit_word_t ZERO_WORD = '{digit: 4'd0, last: 1'b1, bad_radix: 1'b0};
  localparam digit_word_t ERR_WORD  = '{digit: 4'd0, last: 1'b1, bad_radix: 1'b1};

  localparam int DIR_ROWS = 23;

  // Directed items. Rows with a typed word give a single obvious result;
  // the rest are checked through the conversion function.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{31'd0,          4'd2,  1'b1, ZERO_WORD},
    '{31'd0,          4'd9,  1'b1, ZERO_WORD},
    '{31'd0,          4'd0,  1'b1, ERR_WORD},
    '{31'd12345,      4'd1,  1'b1, ERR_WORD},
    '{VALUE_MAX,      4'd10, 1'b1, ERR_WORD},
    '{VALUE_MAX,      4'd15, 1'b1, ERR_WORD},
    '{31'd1,          4'd2,  1'b1, '{digit: 4'd1, last: 1'b1, bad_radix: 1'b0}},
    '{31'd8,          4'd9,  1'b1, '{digit: 4'd8, last: 1'b1, bad_radix: 1'b0}},
    '{VALUE_MAX,      4'd2,  1'b0, NO_WORD},
    '{VALUE_MAX,      4'd9,  1'b0, NO_WORD},
    '{VALUE_MAX,      4'd3,  1'b0, NO_WORD},
    '{31'd1073741824, 4'd2,  1'b0, NO_WORD},
    '{31'd387420489,  4'd9,  1'b0, NO_WORD},
    '{31'd387420488,  4'd9,  1'b0, NO_WORD},
    '{31'd1162261467, 4'd3,  1'b0, NO_WORD},
    '{31'd1073741824, 4'd8,  1'b0, NO_WORD},
    '{31'd1220703125, 4'd5,  1'b0, NO_WORD},
    '{31'd1977326743, 4'd7,  1'b0, NO_WORD},
    '{31'd362797056,  4'd6,  1'b0, NO_WORD},
    '{31'd1073741823, 4'd4,  1'b0, NO_WORD},
    '{31'd9,          4'd9,  1'b0, NO_WORD},
    '{31'h2AAA_AAAA,  4'd2,  1'b0, NO_WORD},
    '{31'h1555_5555,  4'd2,  1'b0, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst;

  digit_word_t digits_due [$];
  int          mismatch_count = 0;
  int          words_seen = 0;
  int          cycle_count = 0;

  rdc_req_if #(.VALUE_BITS(VBITS)) req_ch ();
  rdc_rsp_if                       rsp_ch ();

  radix_digit_converter_top #(.VALUE_BITS(VBITS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue the digit words that a value gives in the given base.
  function automatic void convert_to_digits(input logic [VBITS-1:0] v,
                                            input logic [RADIX_W-1:0] r);
    logic [DIGIT_W-1:0] low_first [$];
    logic [63:0]        rest;
    digit_word_t        w;
    if (r < RADIX_MIN || r > RADIX_MAX) begin
      digits_due.push_back(ERR_WORD);
      return;
    end
    rest = 64'(v);
    do begin
      low_first.push_back(DIGIT_W'(rest % r));
      rest = rest / r;
    end while (rest != 0);
    // The block sends the most significant digit first.
    while (low_first.size() > 0) begin
      w.digit     = low_first.pop_back();
      w.last      = (low_first.size() == 0);
      w.bad_radix = 1'b0;
      digits_due.push_back(w);
    end
  endfunction

  // Offer one word on the input channel and book its results once taken.
  task automatic offer_item(input logic [VBITS-1:0] v, input logic [RADIX_W-1:0] r,
                            input bit no_gap, input logic known,
                            input digit_word_t typed);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.value <= v;
    req_ch.radix <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (known) digits_due.push_back(typed);
    else convert_to_digits(v, r);
  endtask

  // Reset, directed table, random items, then drain and report.
  initial begin : stimulus
    logic [VBITS-1:0]   v;
    logic [RADIX_W-1:0] r;
    logic [63:0]        pw;
    int                 i;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.value <= '0;
    req_ch.radix <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      offer_item(dir_rows[i].value, dir_rows[i].radix, 1'b0,
                 dir_rows[i].known, dir_rows[i].typed);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // Mostly legal bases; the rest spans the whole field.
      if ($urandom_range(0, 4) == 0) r = RADIX_W'($urandom_range(0, 15));
      else r = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
      case ($urandom_range(0, 3))
        0: v = VBITS'($urandom);
        1: v = VBITS'($urandom_range(0, 100));
        2: begin
          // A power of the base, or one off either side of it.
          pw = 64'd1;
          repeat ($urandom_range(1, 30)) begin
            if (pw * r < (64'd1 << VBITS)) pw = pw * r;
          end
          case ($urandom_range(0, 2))
            0: pw = pw - 64'd1;
            1: pw = pw + 64'd1;
            default: ;
          endcase
          v = pw[VBITS-1:0];
        end
        default: v = VBITS'($urandom >> $urandom_range(0, 31));
      endcase
      offer_item(v, r, (i >= CALM_ITEM_LO && i < CALM_ITEM_HI), 1'b0, NO_WORD);
    end
    req_ch.valid <= 1'b0;

    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stalls, one long hold, and a check of every word.
  initial begin : digit_sink
    int          stall;
    digit_word_t want;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (words_seen == HOLD_AT_WORD) stall = HOLD_CYCLES;
      else if (words_seen >= CALM_WORD_LO && words_seen < CALM_WORD_HI) stall = 0;
      else stall = $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      words_seen++;
      if (digits_due.size() == 0) begin
        $error("unexpected word: digit %0d last %0b bad_radix %0b",
               rsp_ch.digit, rsp_ch.last, rsp_ch.bad_radix);
        mismatch_count++;
      end else begin
        want = digits_due.pop_front();
        if (rsp_ch.digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, rsp_ch.digit);
          mismatch_count++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
          mismatch_count++;
        end
        if (rsp_ch.bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %0b, got %0b", want.bad_radix, rsp_ch.bad_radix);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
